### sv/nta_pkg.sv
// Shared types and constants for the nearest track id assigner.
package nta_pkg;

  localparam int MAX_TRACKS = 16;
  localparam int IDX_W      = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int GATE_LAT   = 3;
  localparam int CNT_W      = $clog2(MAX_TRACKS + GATE_LAT);

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_FRAME  = 2'd1;
  localparam logic [1:0] OP_DETECT = 2'd2;

  localparam logic [1:0] CFG_STEP_MODE   = 2'd0;
  localparam logic [1:0] CFG_STEP_MS     = 2'd1;
  localparam logic [1:0] CFG_MAX_AGE     = 2'd2;
  localparam logic [1:0] CFG_MERGE_SPEED = 2'd3;

  localparam logic [15:0] RST_STEP_MS     = 16'd16;
  localparam logic [15:0] RST_MAX_AGE     = 16'd500;
  localparam logic [15:0] RST_MERGE_SPEED = 16'd1280;

  typedef struct packed {
    logic              valid;
    logic              elig;
    logic [IDX_W-1:0]  idx;
    logic [15:0]       ident;
    logic signed [15:0] det_x;
    logic signed [15:0] det_y;
    logic signed [15:0] slot_x;
    logic signed [15:0] slot_y;
    logic [31:0]       slot_time;
    logic [31:0]       cur_time;
    logic [15:0]       speed;
  } gate_req_t;

  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [IDX_W-1:0] idx;
    logic [15:0]      ident;
    logic [32:0]      d2;
  } gate_rsp_t;

endpackage

### sv/nearest_track_id_assigner.sv
// Detection scan: a request accepted in idle runs through SCAN, DECIDE and RESULT, and
// RESULT waits while the output is stalled; no new request is taken until idle again.
// The scan is one pass of the shared gate unit over all MAX_TRACKS slots; frame start
// does one age check per slot; table reset ends in idle; given-id detections skip the scan.
// Synchronous active-low reset clears table flags, counters, times and control state and
// loads config defaults; slot payloads are not cleared and are only read for valid slots.
module nearest_track_id_assigner (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_frame_time_ms,
  input  logic        in_use_given_ids,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic        in_has_id,
  input  logic [15:0] in_given_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_track_id,
  output logic        out_is_new,
  output logic        out_table_full,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam int N  = nta_pkg::MAX_TRACKS;
  localparam int IW = nta_pkg::IDX_W;
  localparam int CW = nta_pkg::CNT_W;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SWEEP  = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_DECIDE = 6'b001000,
    ST_RESULT = 6'b010000,
    ST_SPARE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] idx;

  // configuration
  logic        mode_r;
  logic [15:0] step_r, max_age_r, speed_r;

  // table
  logic [N-1:0]       valid_r, valid_nxt;
  logic [N-1:0]       matched_r, matched_nxt;
  logic [15:0]        slot_id_r   [N];
  logic signed [15:0] slot_x_r    [N];
  logic signed [15:0] slot_y_r    [N];
  logic [31:0]        slot_time_r [N];

  logic          tw_en;
  logic [IW-1:0] tw_idx;
  logic [15:0]   tw_id;

  logic [15:0] next_id_r, next_id_nxt;
  logic [31:0] cur_r, cur_nxt;
  logic [31:0] iclk_r, iclk_nxt;
  logic        keep_r, keep_nxt;

  // current detection
  logic signed [15:0] det_x_r, det_x_nxt, det_y_r, det_y_nxt;

  // scan results
  logic          best_found_r, best_found_nxt;
  logic [IW-1:0] best_idx_r, best_idx_nxt;
  logic [15:0]   best_id_r, best_id_nxt;
  logic [32:0]   best_d2_r, best_d2_nxt;
  logic          id_found_r, id_found_nxt;
  logic [IW-1:0] id_idx_r, id_idx_nxt;
  logic          free_found_r, free_found_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt;

  // pending result
  logic [15:0] res_id_r, res_id_nxt;
  logic        res_new_r, res_new_nxt, res_full_r, res_full_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_id_r;
  logic        out_new_r, out_full_r;
  logic        out_load;

  logic                scan_issue;
  nta_pkg::gate_req_t  greq;
  nta_pkg::gate_rsp_t  grsp;

  assign idx        = cnt_r[IW-1:0];
  assign scan_issue = (state_r == ST_SCAN) && (cnt_r < CW'(N));
  assign in_stall   = (state_r != ST_IDLE);

  assign greq.valid     = scan_issue;
  assign greq.elig      = valid_r[idx] && !matched_r[idx];
  assign greq.idx       = idx;
  assign greq.ident     = slot_id_r[idx];
  assign greq.det_x     = det_x_r;
  assign greq.det_y     = det_y_r;
  assign greq.slot_x    = slot_x_r[idx];
  assign greq.slot_y    = slot_y_r[idx];
  assign greq.slot_time = slot_time_r[idx];
  assign greq.cur_time  = cur_r;
  assign greq.speed     = speed_r;

  nta_gate u_gate (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (greq),
    .rsp   (grsp)
  );

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    valid_nxt      = valid_r;
    matched_nxt    = matched_r;
    next_id_nxt    = next_id_r;
    cur_nxt        = cur_r;
    iclk_nxt       = iclk_r;
    keep_nxt       = keep_r;
    det_x_nxt      = det_x_r;
    det_y_nxt      = det_y_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_id_nxt    = best_id_r;
    best_d2_nxt    = best_d2_r;
    id_found_nxt   = id_found_r;
    id_idx_nxt     = id_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    res_id_nxt     = res_id_r;
    res_new_nxt    = res_new_r;
    res_full_nxt   = res_full_r;
    tw_en          = 1'b0;
    tw_idx         = best_idx_r;
    tw_id          = best_id_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_op)
            nta_pkg::OP_CLEAR: begin
              valid_nxt   = '0;
              matched_nxt = '0;
              next_id_nxt = '0;
              iclk_nxt    = '0;
            end
            nta_pkg::OP_FRAME: begin
              if (mode_r) begin
                cur_nxt  = iclk_r;
                iclk_nxt = iclk_r + {16'h0000, step_r};
              end else begin
                cur_nxt = in_frame_time_ms;
              end
              keep_nxt    = in_use_given_ids;
              matched_nxt = '0;
              cnt_nxt     = '0;
              state_nxt   = ST_SWEEP;
            end
            nta_pkg::OP_DETECT: begin
              det_x_nxt = in_pos_x;
              det_y_nxt = in_pos_y;
              if (keep_r && in_has_id) begin
                res_id_nxt   = in_given_id;
                res_new_nxt  = 1'b0;
                res_full_nxt = 1'b0;
                state_nxt    = ST_RESULT;
              end else begin
                cnt_nxt        = '0;
                best_found_nxt = 1'b0;
                id_found_nxt   = 1'b0;
                free_found_nxt = 1'b0;
                state_nxt      = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SWEEP: begin
        // drop slots older than the age limit
        if (valid_r[idx] && (cur_r > slot_time_r[idx]) &&
            ((cur_r - slot_time_r[idx]) > {16'h0000, max_age_r})) begin
          valid_nxt[idx] = 1'b0;
        end
        if (cnt_r == CW'(N - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SCAN: begin
        if (scan_issue) begin
          if (!id_found_r && valid_r[idx] && (slot_id_r[idx] == next_id_r)) begin
            id_found_nxt = 1'b1;
            id_idx_nxt   = idx;
          end
          if (!free_found_r && !valid_r[idx]) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = idx;
          end
        end
        // strict compare keeps the lowest slot on ties
        if (grsp.valid && grsp.hit && (!best_found_r || (grsp.d2 < best_d2_r))) begin
          best_found_nxt = 1'b1;
          best_idx_nxt   = grsp.idx;
          best_id_nxt    = grsp.ident;
          best_d2_nxt    = grsp.d2;
        end
        if (cnt_r == CW'(N + nta_pkg::GATE_LAT - 1)) begin
          state_nxt = ST_DECIDE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DECIDE: begin
        res_full_nxt = 1'b0;
        if (best_found_r) begin
          tw_en       = 1'b1;
          res_id_nxt  = best_id_r;
          res_new_nxt = 1'b0;
        end else begin
          res_id_nxt  = next_id_r;
          res_new_nxt = 1'b1;
          next_id_nxt = next_id_r + 1'b1;
          tw_id       = next_id_r;
          if (id_found_r) begin
            tw_en  = 1'b1;
            tw_idx = id_idx_r;
          end else if (free_found_r) begin
            tw_en  = 1'b1;
            tw_idx = free_idx_r;
          end else begin
            res_full_nxt = 1'b1;
          end
        end
        if (tw_en) begin
          valid_nxt[tw_idx]   = 1'b1;
          matched_nxt[tw_idx] = 1'b1;
        end
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_load      = (state_r == ST_RESULT) && (!out_valid_r || !out_stall);
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      valid_r      <= '0;
      matched_r    <= '0;
      next_id_r    <= '0;
      cur_r        <= '0;
      iclk_r       <= '0;
      keep_r       <= 1'b0;
      best_found_r <= 1'b0;
      id_found_r   <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
      mode_r       <= 1'b0;
      step_r       <= nta_pkg::RST_STEP_MS;
      max_age_r    <= nta_pkg::RST_MAX_AGE;
      speed_r      <= nta_pkg::RST_MERGE_SPEED;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      valid_r      <= valid_nxt;
      matched_r    <= matched_nxt;
      next_id_r    <= next_id_nxt;
      cur_r        <= cur_nxt;
      iclk_r       <= iclk_nxt;
      keep_r       <= keep_nxt;
      best_found_r <= best_found_nxt;
      id_found_r   <= id_found_nxt;
      free_found_r <= free_found_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          nta_pkg::CFG_STEP_MODE:   mode_r    <= cfg_wdata[0];
          nta_pkg::CFG_STEP_MS:     step_r    <= cfg_wdata;
          nta_pkg::CFG_MAX_AGE:     max_age_r <= cfg_wdata;
          nta_pkg::CFG_MERGE_SPEED: speed_r   <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    det_x_r    <= det_x_nxt;
    det_y_r    <= det_y_nxt;
    best_idx_r <= best_idx_nxt;
    best_id_r  <= best_id_nxt;
    best_d2_r  <= best_d2_nxt;
    id_idx_r   <= id_idx_nxt;
    free_idx_r <= free_idx_nxt;
    res_id_r   <= res_id_nxt;
    res_new_r  <= res_new_nxt;
    res_full_r <= res_full_nxt;
    if (out_load) begin
      out_id_r   <= res_id_r;
      out_new_r  <= res_new_r;
      out_full_r <= res_full_r;
    end
    if (tw_en) begin
      slot_id_r[tw_idx]   <= tw_id;
      slot_x_r[tw_idx]    <= det_x_r;
      slot_y_r[tw_idx]    <= det_y_r;
      slot_time_r[tw_idx] <= cur_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_track_id   = out_id_r;
  assign out_is_new     = out_new_r;
  assign out_table_full = out_full_r;

`ifndef ASSERT_OFF
  a_matched_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (matched_r & ~valid_r) == '0)
    else $error("matched slot is not valid");

  a_out_from_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RESULT))
    else $error("result presented outside the result state");

  a_best_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE) && best_found_r |-> valid_r[best_idx_r] && !matched_r[best_idx_r])
    else $error("nearest slot is not an open track");

  a_id_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (next_id_r != $past(next_id_r)) |->
      ($past(state_r == ST_DECIDE) && !$past(best_found_r)) || (next_id_r == '0))
    else $error("id counter moved without a fresh track");

  a_full_no_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE) && !best_found_r && !id_found_r && !free_found_r |->
      valid_r == '1)
    else $error("table full reported with a free slot");
`endif

endmodule

### sv/nta_gate.sv
// Pipelined distance and gate unit, shared by every slot of a detection scan.
module nta_gate (
  input  logic                clk,
  input  logic                rst_n,
  input  nta_pkg::gate_req_t  req,
  output nta_pkg::gate_rsp_t  rsp
);

  // stage 1: differences and age
  logic                     v1_r, e1_r;
  logic [nta_pkg::IDX_W-1:0] idx1_r;
  logic [15:0]              id1_r;
  logic signed [16:0]       dx1_r, dy1_r;
  logic [31:0]              age1_r;
  logic [15:0]              spd1_r;

  // stage 2: squares and radius
  logic                     v2_r, e2_r;
  logic [nta_pkg::IDX_W-1:0] idx2_r;
  logic [15:0]              id2_r;
  logic [31:0]              dx2_r, dy2_r;
  logic [47:0]              g2_r;

  // stage 3: distance sum and squared radius
  logic                     v3_r, e3_r;
  logic [nta_pkg::IDX_W-1:0] idx3_r;
  logic [15:0]              id3_r;
  logic [32:0]              d2_r;
  logic                     big3_r;
  logic [49:0]              gg3_r;

  logic signed [33:0]       sqx, sqy;
  logic [16:0]              dx_nxt, dy_nxt;

  assign dx_nxt = {req.det_x[15], req.det_x} - {req.slot_x[15], req.slot_x};
  assign dy_nxt = {req.det_y[15], req.det_y} - {req.slot_y[15], req.slot_y};
  assign sqx    = dx1_r * dx1_r;
  assign sqy    = dy1_r * dy1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= req.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    e1_r   <= req.elig && (req.cur_time > req.slot_time);
    idx1_r <= req.idx;
    id1_r  <= req.ident;
    dx1_r  <= $signed(dx_nxt);
    dy1_r  <= $signed(dy_nxt);
    age1_r <= req.cur_time - req.slot_time;
    spd1_r <= req.speed;

    e2_r   <= e1_r;
    idx2_r <= idx1_r;
    id2_r  <= id1_r;
    dx2_r  <= sqx[31:0];
    dy2_r  <= sqy[31:0];
    g2_r   <= age1_r * spd1_r;

    e3_r   <= e2_r;
    idx3_r <= idx2_r;
    id3_r  <= id2_r;
    d2_r   <= {1'b0, dx2_r} + {1'b0, dy2_r};
    // radius of 2^17 mm or more covers any distance
    big3_r <= |g2_r[47:25];
    gg3_r  <= g2_r[24:0] * g2_r[24:0];
  end

  assign rsp.valid = v3_r;
  assign rsp.hit   = e3_r && (big3_r || ({1'b0, d2_r, 16'h0000} < gg3_r));
  assign rsp.idx   = idx3_r;
  assign rsp.ident = id3_r;
  assign rsp.d2    = d2_r;

endmodule
